>>> src/c2p_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_pkg: shared types and constants for the Cartesian-to-polar converter
// Holds the word formats of both channels, the pipeline depths and the
// arctangent table used by the CORDIC stages.
// ----------------------------------------------------------------------------
package c2p_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int ANGLE_WIDTH = 16;

    // CORDIC datapath: 64-bit signed coordinates, 32-bit turn accumulator.
    localparam int DW        = 64;
    localparam int ZW        = 32;
    localparam int ITERS     = 32;
    localparam int SCALE_POS = 60;

    // Depth of each path, counted in register stages.
    localparam int CORDIC_LAT = ITERS + 2;
    localparam int SQRT_LAT   = COORD_WIDTH + 4;
    localparam int PIPE_LAT   = (CORDIC_LAT > SQRT_LAT) ? CORDIC_LAT : SQRT_LAT;

    localparam logic [ZW-1:0] HALF_TURN = ZW'(1) << (ZW - 1);

    localparam logic [ANGLE_WIDTH-1:0] ANG_QUARTER = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
    localparam logic [ANGLE_WIDTH-1:0] ANG_HALF    = ANG_QUARTER << 1;
    localparam logic [ANGLE_WIDTH-1:0] ANG_3QUART  = ANG_HALF + ANG_QUARTER;

    // atan(2^-i) in units of 2^-32 turn.
    localparam logic [ZW-1:0] ATAN_TURNS [ITERS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_coord;
        logic signed [COORD_WIDTH-1:0] y_coord;
    } t_c2p_in;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] magnitude;
        logic [ANGLE_WIDTH-1:0] angle;
    } t_c2p_out;

endpackage
`default_nettype wire

>>> src/c2p_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_cordic: pipelined CORDIC vectoring unit for the angle
// One micro-rotation per stage after a setup stage that folds the left half
// plane and detects the axes, then a rounding stage and delay to match depth.
// ----------------------------------------------------------------------------
module c2p_cordic (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_en,
    input  wire logic signed [c2p_pkg::COORD_WIDTH-1:0] i_x,
    input  wire logic signed [c2p_pkg::COORD_WIDTH-1:0] i_y,
    output logic             [c2p_pkg::ANGLE_WIDTH-1:0] o_angle
);
    import c2p_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int AW  = ANGLE_WIDTH;
    localparam int PAD = PIPE_LAT - CORDIC_LAT;

    logic signed [DW-1:0] s_x    [0:ITERS];
    logic signed [DW-1:0] s_y    [0:ITERS];
    logic        [ZW-1:0] s_z    [0:ITERS];
    logic                 s_spec [0:ITERS];
    logic        [AW-1:0] s_sang [0:ITERS];

    logic signed [DW-1:0] x_ext, y_ext, x_fold, y_fold;
    logic        [AW-1:0] n_sang;
    logic        [AW-1:0] z_rnd;
    logic        [AW-1:0] r_ang;

    logic signed [DW-1:0] r_x0, r_y0;
    logic        [ZW-1:0] r_z0;
    logic                 r_spec0;
    logic        [AW-1:0] r_sang0;

    // Setup: points with negative x are turned by half a turn.
    assign x_ext  = {{(DW-CW){i_x[CW-1]}}, i_x};
    assign y_ext  = {{(DW-CW){i_y[CW-1]}}, i_y};
    assign x_fold = i_x[CW-1] ? -x_ext : x_ext;
    assign y_fold = i_x[CW-1] ? -y_ext : y_ext;

    always_comb begin
        if (i_x == '0) begin
            if (i_y == '0) begin
                n_sang = '0;
            end else if (!i_y[CW-1]) begin
                n_sang = ANG_QUARTER;
            end else begin
                n_sang = ANG_3QUART;
            end
        end else begin
            n_sang = i_x[CW-1] ? ANG_HALF : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0    <= x_fold <<< (SCALE_POS - CW);
            r_y0    <= y_fold <<< (SCALE_POS - CW);
            r_z0    <= i_x[CW-1] ? HALF_TURN : '0;
            r_spec0 <= (i_x == '0) || (i_y == '0);
            r_sang0 <= n_sang;
        end
    end

    assign s_x[0]    = r_x0;
    assign s_y[0]    = r_y0;
    assign s_z[0]    = r_z0;
    assign s_spec[0] = r_spec0;
    assign s_sang[0] = r_sang0;

    generate
        for (genvar i = 0; i < ITERS; i++) begin : g_iter
            logic signed [DW-1:0] dx, dy;
            logic signed [DW-1:0] r_x, r_y;
            logic        [ZW-1:0] r_z;
            logic                 r_spec;
            logic        [AW-1:0] r_sang;

            assign dx = s_y[i] >>> i;
            assign dy = s_x[i] >>> i;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!s_y[i][DW-1]) begin
                        r_x <= s_x[i] + dx;
                        r_y <= s_y[i] - dy;
                        r_z <= s_z[i] + ATAN_TURNS[i];
                    end else begin
                        r_x <= s_x[i] - dx;
                        r_y <= s_y[i] + dy;
                        r_z <= s_z[i] - ATAN_TURNS[i];
                    end
                    r_spec <= s_spec[i];
                    r_sang <= s_sang[i];
                end
            end

            assign s_x[i+1]    = r_x;
            assign s_y[i+1]    = r_y;
            assign s_z[i+1]    = r_z;
            assign s_spec[i+1] = r_spec;
            assign s_sang[i+1] = r_sang;
        end

        // Round the turn accumulator to the output width; a carry out of the
        // top bit wraps a full turn back to zero.
        if (AW < ZW) begin : g_round
            localparam logic [ZW-1:0] ROUND_ADD = ZW'(1) << (ZW - 1 - AW);
            logic [ZW-1:0] z_sum;
            assign z_sum = s_z[ITERS] + ROUND_ADD;
            assign z_rnd = z_sum[ZW-1 -: AW];
        end else begin : g_noround
            assign z_rnd = s_z[ITERS][ZW-1 -: AW];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= s_spec[ITERS] ? s_sang[ITERS] : z_rnd;
        end
    end

    generate
        if (PAD > 0) begin : g_pad
            logic [AW-1:0] r_pad [PAD];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pad[0] <= r_ang;
                    for (int k = 1; k < PAD; k++) begin
                        r_pad[k] <= r_pad[k-1];
                    end
                end
            end
            assign o_angle = r_pad[PAD-1];
        end else begin : g_nopad
            assign o_angle = r_ang;
        end
    endgenerate

endmodule
`default_nettype wire

>>> src/c2p_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_sqrt: pipelined magnitude unit
// Squares the absolute coordinates, adds them, extracts the integer square
// root one bit per stage and rounds it to nearest using the final remainder.
// ----------------------------------------------------------------------------
module c2p_sqrt (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_en,
    input  wire logic signed [c2p_pkg::COORD_WIDTH-1:0] i_x,
    input  wire logic signed [c2p_pkg::COORD_WIDTH-1:0] i_y,
    output logic             [c2p_pkg::COORD_WIDTH-1:0] o_mag
);
    import c2p_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int RW  = CW + 2;
    localparam int NW  = 2 * CW;
    localparam int PAD = PIPE_LAT - SQRT_LAT;

    logic [CW-1:0] r_ax, r_ay;
    logic [NW-1:0] r_sqx, r_sqy, r_sum;
    logic [CW-1:0] r_mag;

    logic [RW-1:0] s_rem  [0:CW];
    logic [CW-1:0] s_root [0:CW];
    logic [NW-1:0] s_rad  [0:CW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax  <= i_x[CW-1] ? CW'(-i_x) : CW'(i_x);
            r_ay  <= i_y[CW-1] ? CW'(-i_y) : CW'(i_y);
            r_sqx <= r_ax * r_ax;
            r_sqy <= r_ay * r_ay;
            r_sum <= r_sqx + r_sqy;
        end
    end

    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_rad[0]  = r_sum;

    // Restoring square root, most significant radicand pair first.
    generate
        for (genvar k = 0; k < CW; k++) begin : g_digit
            localparam int P = CW - 1 - k;
            logic [RW+1:0] rem_sh, trial;
            logic [RW-1:0] r_rem;
            logic [CW-1:0] r_root;
            logic [NW-1:0] r_rad;

            assign rem_sh = {s_rem[k], s_rad[k][2*P+1 -: 2]};
            assign trial  = {2'b00, s_root[k], 2'b01};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (rem_sh >= trial) begin
                        r_rem  <= RW'(rem_sh - trial);
                        r_root <= {s_root[k][CW-2:0], 1'b1};
                    end else begin
                        r_rem  <= RW'(rem_sh);
                        r_root <= {s_root[k][CW-2:0], 1'b0};
                    end
                    r_rad <= s_rad[k];
                end
            end

            assign s_rem[k+1]  = r_rem;
            assign s_root[k+1] = r_root;
            assign s_rad[k+1]  = r_rad;
        end
    endgenerate

    // The remainder is n - root^2, so the root rounds up when it exceeds root.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (s_rem[CW] > {2'b00, s_root[CW]}) begin
                r_mag <= s_root[CW] + 1'b1;
            end else begin
                r_mag <= s_root[CW];
            end
        end
    end

    generate
        if (PAD > 0) begin : g_pad
            logic [CW-1:0] r_pad [PAD];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pad[0] <= r_mag;
                    for (int k = 1; k < PAD; k++) begin
                        r_pad[k] <= r_pad[k-1];
                    end
                end
            end
            assign o_mag = r_pad[PAD-1];
        end else begin : g_nopad
            assign o_mag = r_mag;
        end
    endgenerate

endmodule
`default_nettype wire

>>> src/cartesian_to_polar_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cartesian_to_polar_top: streaming Cartesian-to-polar converter
// Converts each signed (x, y) word into a rounded magnitude and an angle
// given as an unsigned binary fraction of a full turn.
// ----------------------------------------------------------------------------
// The block takes one word per clock while o_stall is low and returns one
// result word for each, in order. The depth is set by the 32 CORDIC
// micro-rotation stages of the angle path plus their setup and rounding
// stages, and the magnitude path is delayed to match. A two-entry output
// buffer absorbs one word of backpressure, so the input stall is a
// registered signal and the pipeline holds while it is high.
// The origin gives angle zero, and points on an axis give exact multiples of
// a quarter turn.
module cartesian_to_polar_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire c2p_pkg::t_c2p_in  i_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output c2p_pkg::t_c2p_out      o_data
);
    import c2p_pkg::*;

    logic                   en;
    logic [PIPE_LAT-1:0]    r_vld;
    logic [COORD_WIDTH-1:0] pipe_mag;
    logic [ANGLE_WIDTH-1:0] pipe_ang;
    t_c2p_out               pipe_word;
    logic                   pipe_valid;

    logic                   r_out_valid;
    t_c2p_out               r_out;
    logic                   r_skid_valid;
    t_c2p_out               r_skid;

    // The whole pipeline moves while the skid entry is free.
    assign en      = !r_skid_valid;
    assign o_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
        end
    end

    c2p_cordic u_cordic (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (i_data.x_coord),
        .i_y     (i_data.y_coord),
        .o_angle (pipe_ang)
    );

    c2p_sqrt u_sqrt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (i_data.x_coord),
        .i_y   (i_data.y_coord),
        .o_mag (pipe_mag)
    );

    assign pipe_valid          = r_vld[PIPE_LAT-1];
    assign pipe_word.magnitude = pipe_mag;
    assign pipe_word.angle     = pipe_ang;

    // A word leaving the pipeline goes to the output register when it is free
    // or being taken, and otherwise parks in the skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (en) begin
            if (!r_out_valid || !i_stall) begin
                r_out_valid <= pipe_valid;
                r_out       <= pipe_word;
            end else if (pipe_valid) begin
                r_skid_valid <= 1'b1;
                r_skid       <= pipe_word;
            end
        end else if (!i_stall) begin
            r_out        <= r_skid;
            r_skid_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire

>>> test/tb_cartesian_to_polar_top.sv
// ----------------------------------------------------------------------------
// tb_cartesian_to_polar_top: self-checking bench for the polar converter
// Streams coordinate words through the block under random idling on both
// sides and checks every result word against a local CORDIC and square-root
// predictor, in order, field by field.
// ----------------------------------------------------------------------------
module tb_cartesian_to_polar_top;
    import c2p_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = c2p_pkg::PIPE_LAT + 16;
    localparam int CORDIC_STEPS = 32;
    localparam int SCALE_SHIFT  = 60 - COORD_WIDTH;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    t_c2p_in  i_data  = '0;
    logic     i_stall = 1'b0;
    logic     o_stall;
    logic     o_valid;
    t_c2p_out o_data;

    t_c2p_in  pending_points [$];
    t_c2p_out expected_polar [$];
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    logic     hold_go   = 1'b0;
    logic     hold_done = 1'b0;
    int       hold_count = 0;
    int       cycle_count = 0;
    int       errors = 0;

    cartesian_to_polar_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #4 i_clk = ~i_clk;

    // atan(2^-i) in units of 2^-32 turn.
    function automatic logic [31:0] atan_step(int i);
        case (i)
            0:  return 32'd536870912;  1:  return 32'd316933406;
            2:  return 32'd167458907;  3:  return 32'd85004756;
            4:  return 32'd42667331;   5:  return 32'd21354465;
            6:  return 32'd10679838;   7:  return 32'd5340245;
            8:  return 32'd2670163;    9:  return 32'd1335087;
            10: return 32'd667544;     11: return 32'd333772;
            12: return 32'd166886;     13: return 32'd83443;
            14: return 32'd41722;      15: return 32'd20861;
            16: return 32'd10430;      17: return 32'd5215;
            18: return 32'd2608;       19: return 32'd1304;
            20: return 32'd652;        21: return 32'd326;
            22: return 32'd163;        23: return 32'd81;
            24: return 32'd41;         25: return 32'd20;
            26: return 32'd10;         27: return 32'd5;
            28: return 32'd3;          29: return 32'd1;
            30: return 32'd1;          default: return 32'd0;
        endcase
    endfunction

    function automatic logic [COORD_WIDTH-1:0] rounded_length(longint unsigned n);
        longint unsigned rem, root, probe;
        rem   = n;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > rem) probe >>= 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe >>= 2;
        end
        if (n > root * root + root) root++;
        return root[COORD_WIDTH-1:0];
    endfunction

    // Vectoring CORDIC on coordinates scaled to the top of a 64-bit word;
    // the turn accumulator wraps naturally at 32 bits.
    function automatic logic [ANGLE_WIDTH-1:0] cordic_direction(longint xc, longint yc);
        longint      xs, ys, dx, dy;
        logic [31:0] turns;
        logic [32:0] rounded;
        turns = 32'd0;
        if (xc < 0) begin
            xc    = -xc;
            yc    = -yc;
            turns = 32'h8000_0000;
        end
        xs = xc <<< SCALE_SHIFT;
        ys = yc <<< SCALE_SHIFT;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = ys >>> i;
            dy = xs >>> i;
            if (ys >= 0) begin
                xs    = xs + dx;
                ys    = ys - dy;
                turns = turns + atan_step(i);
            end else begin
                xs    = xs - dx;
                ys    = ys + dy;
                turns = turns - atan_step(i);
            end
        end
        rounded = {1'b0, turns} + (33'd1 << (31 - ANGLE_WIDTH));
        return rounded[31 -: ANGLE_WIDTH];
    endfunction

    function automatic t_c2p_out polar_of(t_c2p_in p);
        longint             xc, yc;
        t_c2p_out           r;
        logic [ANGLE_WIDTH-1:0] quarter;
        xc      = longint'($signed(p.x_coord));
        yc      = longint'($signed(p.y_coord));
        quarter = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
        r.magnitude = rounded_length(longint'(unsigned'(xc * xc + yc * yc)));
        if (xc == 0) begin
            if (yc == 0)     r.angle = '0;
            else if (yc > 0) r.angle = quarter;
            else             r.angle = ANGLE_WIDTH'(quarter * 3);
        end else if (yc == 0) begin
            r.angle = (xc > 0) ? '0 : ANGLE_WIDTH'(quarter * 2);
        end else begin
            r.angle = cordic_direction(xc, yc);
        end
        return r;
    endfunction

    task automatic queue_point(int xv, int yv);
        t_c2p_in p;
        p.x_coord = xv[COORD_WIDTH-1:0];
        p.y_coord = yv[COORD_WIDTH-1:0];
        pending_points = {pending_points, p};
    endtask

    function automatic int edge_value();
        case ($urandom_range(6))
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return 32766;
            default: return 32767;
        endcase
    endfunction

    task automatic queue_random_points(int count);
        int xv, yv;
        for (int k = 0; k < count; k++) begin
            xv = int'($urandom_range(65535)) - 32768;
            yv = int'($urandom_range(65535)) - 32768;
            case ($urandom_range(9))
                6: begin
                    xv = int'($urandom_range(16)) - 8;
                    yv = int'($urandom_range(16)) - 8;
                end
                7: begin
                    if ($urandom_range(1)) xv = 0;
                    else                   yv = 0;
                end
                8: begin
                    xv = edge_value();
                    yv = edge_value();
                end
                9: begin
                    // Points near a diagonal exercise long CORDIC runs of one sign.
                    yv = xv + int'($urandom_range(4)) - 2;
                    if ($urandom_range(1)) yv = -yv;
                end
                default: ;
            endcase
            queue_point(xv, yv);
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_points.size() != 0 || i_valid || expected_polar.size() != 0);
    endtask

    // Sender: a word that was not taken stays on the bus unchanged.
    always @(posedge i_clk) begin
        logic take;
        take = i_valid && !o_stall;
        if (take) expected_polar = {expected_polar, polar_of(i_data)};
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !take) begin
            i_valid <= 1'b1;
        end else if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            i_valid <= 1'b1;
            i_data  <= pending_points.pop_front();
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Receiver: one long hold-off when requested, random stalls otherwise.
    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            i_stall    <= 1'b1;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_c2p_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_polar.size() == 0) begin
                $display("%0t: result word with none expected: magnitude %0d angle %0d",
                         $time, o_data.magnitude, o_data.angle);
                errors++;
            end else begin
                want = expected_polar.pop_front();
                if (o_data.magnitude !== want.magnitude) begin
                    $display("%0t: magnitude mismatch: expected %0d, actual %0d",
                             $time, want.magnitude, o_data.magnitude);
                    errors++;
                end
                if (o_data.angle !== want.angle) begin
                    $display("%0t: angle mismatch: expected %0d, actual %0d",
                             $time, want.angle, o_data.angle);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, expected_polar.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        send_idle_pct = 34;
        recv_idle_pct = 68;
        // Origin, the four half axes, the range corners and points near origin and edges.
        queue_point(0, 0);
        queue_point(32767, 0);
        queue_point(-32768, 0);
        queue_point(0, 32767);
        queue_point(0, -32768);
        queue_point(-1, 0);
        queue_point(0, -1);
        queue_point(32767, 32767);
        queue_point(-32768, -32768);
        queue_point(-32768, 32767);
        queue_point(32767, -32768);
        queue_point(1, 1);
        queue_point(-1, -1);
        queue_point(1, -1);
        queue_point(-1, 1);
        queue_point(-32768, 1);
        queue_point(-32768, -1);
        queue_point(1, -32768);
        // Just below the positive x axis the angle can round up to a full turn
        // and then has to wrap to zero.
        queue_point(32767, -1);
        queue_point(32767, -2);
        queue_point(3, 4);
        queue_point(-3, -4);
        queue_random_points(220);
        wait_drained();

        send_idle_pct = 68;
        recv_idle_pct = 34;
        queue_random_points(215);
        wait_drained();

        // No idling; the receiver holds off long enough for the pipeline to
        // fill and push back on the sender.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go       = 1'b1;
        queue_random_points(215);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_polar.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
